// ----- src/bsp_pkg.sv -----
package bsp_pkg;

  // number of BAR slots and index width
  localparam int unsigned BarSlots   = 6;
  localparam int unsigned SlotW      = 3;

  // allocator constants
  localparam logic [31:0] WindowBaseReset = 32'hD000_0000;
  localparam int unsigned AlignW          = 28;  // largest window handed out is 2^AlignW

  // decoded view of one probed BAR
  typedef struct packed {
    logic              present;
    logic [3:0]        flags;
    logic              wide;
    logic [63:0]       size;
    logic [63:0]       addr;
    logic              alloc_ok;
    logic [AlignW-1:0] align;
  } decode_t;

  // one result word
  typedef struct packed {
    logic        present;
    logic [3:0]  flags;
    logic        wide;
    logic [63:0] size;
    logic [63:0] addr;
    logic        reassigned;
    logic [15:0] total;
  } result_t;

endpackage

// ----- src/bar_size_probe_window_allocator_unit.sv -----
// BAR sizing and window allocator. Each input word is one probed BAR (values before and
// after writing all ones); each produces exactly one result word with flags, 64-bit mark,
// decoded size, final base and a saturating count of BARs with nonzero size. Memory BARs
// that are unassigned or above 4G and no larger than 256M get a base below 4G, if one
// fits, from a size-aligned bump pointer that starts at window_base (0xD0000000 after
// reset; a write to window_base_i also restarts the pointer). Words pass the input
// register, then the result register; one word is taken every cycle unless the output
// stalls, the rate set by the add, align and compare loop that updates the bump pointer.
// No clearing pass after reset. Write window_base only while no word is in flight.
module bar_size_probe_window_allocator_unit import bsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              window_base_we_i,
  input  logic [31:0]       window_base_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SlotW-1:0]  bar_index_i,
  input  logic [31:0]       original_low_i,
  input  logic [31:0]       orig_upper_i,
  input  logic [31:0]       mask_low_i,
  input  logic [31:0]       mask_high_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              present_o,
  output logic [3:0]        flags_o,
  output logic              is_wide_o,
  output logic [63:0]       window_size_o,
  output logic [63:0]       window_address_o,
  output logic              reassigned_o,
  output logic [15:0]       resource_total_o
);

  logic             in_valid_q, in_valid_d;
  logic [SlotW-1:0] idx_q;
  logic [31:0]      orig_lo_q, orig_hi_q, mask_lo_q, mask_hi_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  logic             in_load;
  logic             adv;
  decode_t          dec;
  result_t          res;

  // handshake: word moves to the result register when that register frees up
  assign adv         = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !adv;
  assign in_load     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_load || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      idx_q     <= bar_index_i;
      orig_lo_q <= original_low_i;
      orig_hi_q <= orig_upper_i;
      mask_lo_q <= mask_low_i;
      mask_hi_q <= mask_high_i;
    end
  end

  bsp_decode u_decode (
    .bar_index_i     (idx_q),
    .original_low_i  (orig_lo_q),
    .orig_upper_i    (orig_hi_q),
    .mask_low_i      (mask_lo_q),
    .mask_high_i     (mask_hi_q),
    .dec_o           (dec)
  );

  bsp_alloc u_alloc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (adv),
    .base_we_i (window_base_we_i),
    .base_i    (window_base_i),
    .dec_i     (dec),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign present_o        = out_q.present;
  assign flags_o          = out_q.flags;
  assign is_wide_o        = out_q.wide;
  assign window_size_o    = out_q.size;
  assign window_address_o = out_q.addr;
  assign reassigned_o     = out_q.reassigned;
  assign resource_total_o = out_q.total;

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("word advanced but result register not valid");

  a_new_addr_below_4g: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reassigned_o) |-> (window_address_o[63:32] == 32'd0))
    else $error("assigned base at or above 4G");

  a_new_addr_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reassigned_o) |->
      (window_size_o != 64'd0 && window_size_o <= 64'h1000_0000))
    else $error("window assigned with size out of range");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !present_o) |->
      (window_size_o == 64'd0 && !reassigned_o && !is_wide_o && flags_o == 4'd0))
    else $error("skipped BAR carries decoded fields");
`endif

endmodule

// ----- src/bsp_decode.sv -----
module bsp_decode import bsp_pkg::*; (
  input  logic [SlotW-1:0] bar_index_i,
  input  logic [31:0]      original_low_i,
  input  logic [31:0]      orig_upper_i,
  input  logic [31:0]      mask_low_i,
  input  logic [31:0]      mask_high_i,
  output decode_t          dec_o
);

  logic        is_io;
  logic        wide;
  logic        in_range;
  logic [31:0] lo;
  logic [63:0] mask64;
  logic        unassigned;
  logic        above_4g;
  logic        size_ok;

  // type and slot checks
  assign in_range = (bar_index_i < SlotW'(BarSlots));
  assign is_io    = original_low_i[0];
  assign wide     = !is_io && (original_low_i[2:1] == 2'b10)
                    && (bar_index_i < SlotW'(BarSlots - 1));

  // size from the inverted readback mask
  assign lo     = {mask_low_i[31:4], 4'b0000};
  assign mask64 = wide ? {mask_high_i, lo} : {32'd0, lo};

  // size of at most 2^AlignW and nonzero: top mask bits all ones
  assign size_ok = (&lo[31:AlignW]) && (!wide || (&mask_high_i));

  // current address state
  assign above_4g   = wide && (orig_upper_i != 32'd0);
  assign unassigned = (original_low_i[31:4] == 28'd0) && !above_4g;

  always_comb begin
    dec_o          = '0;
    dec_o.present  = (original_low_i != 32'd0) && in_range;
    if (dec_o.present) begin
      dec_o.flags    = original_low_i[3:0];
      dec_o.wide     = wide;
      dec_o.size     = wide ? (~mask64 + 64'd1) : {32'd0, ~lo + 32'd1};
      dec_o.addr     = {wide ? orig_upper_i : 32'd0, original_low_i[31:4], 4'b0000};
      dec_o.alloc_ok = !is_io && (unassigned || above_4g) && size_ok;
      dec_o.align    = ~lo[AlignW-1:0];
    end
  end

endmodule

// ----- src/bsp_alloc.sv -----
module bsp_alloc import bsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        commit_i,
  input  logic        base_we_i,
  input  logic [31:0] base_i,
  input  decode_t     dec_i,
  output result_t     res_o
);

  logic [32:0]       next_free_q, next_free_d;
  logic [15:0]       count_q, count_d;
  logic [33:0]       sum;
  logic [33:0]       cand;
  logic [AlignW:0]   size_s;
  logic [34:0]       win_end;
  logic              fits;
  logic              grant;
  logic              count_inc;

  // size-aligned bump of the free pointer
  assign sum     = {1'b0, next_free_q} + {{(34 - AlignW){1'b0}}, dec_i.align};
  assign cand    = sum & ~{{(34 - AlignW){1'b0}}, dec_i.align};
  assign size_s  = {1'b0, dec_i.align} + {{AlignW{1'b0}}, 1'b1};
  assign win_end = {1'b0, cand} + {{(34 - AlignW){1'b0}}, size_s};
  assign fits    = (cand[33:32] == 2'b00) && (win_end <= 35'h1_0000_0000);
  assign grant   = dec_i.present && dec_i.alloc_ok && fits;

  // saturating resource count
  assign count_inc = dec_i.present && (dec_i.size != 64'd0) && (count_q != 16'hFFFF);

  always_comb begin
    next_free_d = next_free_q;
    count_d     = count_q;
    if (base_we_i) begin
      next_free_d = {1'b0, base_i};
    end else if (commit_i) begin
      if (grant) begin
        next_free_d = win_end[32:0];
      end
      if (count_inc) begin
        count_d = count_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= {1'b0, WindowBaseReset};
      count_q     <= '0;
    end else begin
      next_free_q <= next_free_d;
      count_q     <= count_d;
    end
  end

  // result word
  always_comb begin
    res_o            = '0;
    res_o.present    = dec_i.present;
    res_o.flags      = dec_i.flags;
    res_o.wide       = dec_i.wide;
    res_o.size       = dec_i.size;
    res_o.addr       = grant ? {30'd0, cand} : dec_i.addr;
    res_o.reassigned = grant;
    res_o.total      = count_inc ? count_q + 16'd1 : count_q;
  end

endmodule
